[design/tccw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console character writer: shared definitions
// Field widths, codes, defaults and the command word that passes from the
// front end to the back end.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Default screen geometry.
  localparam int COLS_DEF      = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  // Port field widths.
  localparam int ACTION_W  = 3;
  localparam int CHAR_W    = 8;
  localparam int POS_IN_W  = 8;
  localparam int INDEX_W   = 11;
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;
  localparam int OFFSET_W  = 11;
  localparam int CELL_W    = 16;
  localparam int COLOUR_W  = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

  // Colour reset values.
  localparam logic [COLOUR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOUR_W-1:0] BG_RESET = 4'h0;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Blank cell written by the clearing pass after reset.
  localparam logic [CELL_W-1:0] RESET_BLANK = {BG_RESET, FG_RESET, CH_SPACE};

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Input action codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT    = 3'd0,
    ACT_CLEAR  = 3'd1,
    ACT_SETCOL = 3'd2,
    ACT_SETROW = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  // Classified operations handed to the back end.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_BS,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_PUT,
    OP_CLEAR,
    OP_SETCOL,
    OP_SETROW,
    OP_READ
  } op_e;

  // Command word; column and row are already saturated to the screen.
  typedef struct packed {
    op_e                 op;
    logic [CHAR_W-1:0]   char_code;
    logic [POS_IN_W-1:0] col;
    logic [POS_IN_W-1:0] row;
    logic [INDEX_W-1:0]  index;
  } cmd_t;

endpackage

[design/tccw_ram.sv]
// ----------------------------------------------------------------------------
// Text console character writer: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/tccw_front.sv]
// ----------------------------------------------------------------------------
// Text console character writer: front end
// Accepts input words, classifies them into commands and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module tccw_front #(
  parameter int COLS = tccw_pkg::COLS_DEF,
  parameter int ROWS = tccw_pkg::ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           init_busy_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tccw_pkg::ACTION_W-1:0]  action_i,
  input  logic [tccw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tccw_pkg::POS_IN_W-1:0]  new_col_i,
  input  logic [tccw_pkg::POS_IN_W-1:0]  new_row_i,
  input  logic [tccw_pkg::INDEX_W-1:0]   cell_index_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output tccw_pkg::cmd_t                 cmd_o
);

  localparam int Depth = tccw_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int PosW  = tccw_pkg::POS_IN_W;
  localparam logic [PosW-1:0] ColMax = PosW'(COLS - 1);
  localparam logic [PosW-1:0] RowMax = PosW'(ROWS - 1);

  tccw_pkg::cmd_t       queue_q [Depth];
  tccw_pkg::cmd_t       cmd_new;
  logic [PtrW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 push, pop;

  // Classify the incoming word.
  always_comb begin
    cmd_new.char_code = char_code_i;
    cmd_new.index     = cell_index_i;
    cmd_new.col       = (new_col_i > ColMax) ? ColMax : new_col_i;
    cmd_new.row       = (new_row_i > RowMax) ? RowMax : new_row_i;
    cmd_new.op        = tccw_pkg::OP_NOP;
    unique case (action_i)
      tccw_pkg::ACT_PUT: begin
        priority if (char_code_i == tccw_pkg::CH_BS) begin
          cmd_new.op = tccw_pkg::OP_BS;
        end else if (char_code_i == tccw_pkg::CH_TAB) begin
          cmd_new.op = tccw_pkg::OP_TAB;
        end else if (char_code_i == tccw_pkg::CH_CR) begin
          cmd_new.op = tccw_pkg::OP_CR;
        end else if (char_code_i == tccw_pkg::CH_LF) begin
          cmd_new.op = tccw_pkg::OP_LF;
        end else if (!char_code_i[tccw_pkg::CHAR_W-1] &&
                     (char_code_i >= tccw_pkg::CH_SPACE)) begin
          cmd_new.op = tccw_pkg::OP_PUT;
        end else begin
          cmd_new.op = tccw_pkg::OP_NOP;
        end
      end
      tccw_pkg::ACT_CLEAR:  cmd_new.op = tccw_pkg::OP_CLEAR;
      tccw_pkg::ACT_SETCOL: cmd_new.op = tccw_pkg::OP_SETCOL;
      tccw_pkg::ACT_SETROW: cmd_new.op = tccw_pkg::OP_SETROW;
      tccw_pkg::ACT_READ:   cmd_new.op = tccw_pkg::OP_READ;
      default:              cmd_new.op = tccw_pkg::OP_NOP;
    endcase
  end

  // Queue handshakes; nothing is taken during the clearing pass after reset.
  assign in_ready_o  = (count_q != CntW'(Depth)) && !init_busy_i;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[head_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Pointer and fill count updates.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push) begin
      tail_d = (tail_q == PtrW'(Depth - 1)) ? '0 : tail_q + PtrW'(1);
    end
    if (pop) begin
      head_d = (head_q == PtrW'(Depth - 1)) ? '0 : head_q + PtrW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[tail_q] <= cmd_new;
    end
  end

endmodule

[design/tccw_back.sv]
// ----------------------------------------------------------------------------
// Text console character writer: back end
// Carries out commands on the cursor and the screen memory, sequences the
// reset clear, screen clear and scroll sweeps, and holds the result word.
// ----------------------------------------------------------------------------
module tccw_back #(
  parameter int COLS      = tccw_pkg::COLS_DEF,
  parameter int ROWS      = tccw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tccw_pkg::TAB_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  output logic                            init_busy_o,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  input  tccw_pkg::cmd_t                  cmd_i,
  input  logic                            cfg_valid_i,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tccw_pkg::COLOUR_W-1:0]   cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tccw_pkg::OUT_COL_W-1:0]  cursor_col_o,
  output logic [tccw_pkg::OUT_ROW_W-1:0]  cursor_row_o,
  output logic [tccw_pkg::OFFSET_W-1:0]   cursor_offset_o,
  output logic [tccw_pkg::CELL_W-1:0]     cell_word_o,
  output logic                            scrolled_o
);

  localparam int Cells   = COLS * ROWS;
  localparam int Move    = (ROWS - 1) * COLS;
  localparam int AddrW   = $clog2(Cells);
  localparam int ColW    = $clog2(COLS);
  localparam int RowW    = $clog2(ROWS);
  localparam int NextW   = $clog2(COLS + TAB_WIDTH);
  localparam int CellW   = tccw_pkg::CELL_W;
  localparam int OutColW = tccw_pkg::OUT_COL_W;
  localparam int OutRowW = tccw_pkg::OUT_ROW_W;
  localparam int OffW    = tccw_pkg::OFFSET_W;
  localparam logic [AddrW-1:0] LastCell = AddrW'(Cells - 1);
  localparam logic [AddrW-1:0] MoveEnd  = AddrW'(Move);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_FILL,
    ST_READ
  } state_e;

  state_e                          state_q, state_d;
  logic [AddrW-1:0]                ptr_q, ptr_d;
  logic [ColW-1:0]                 col_q, col_d;
  logic [RowW-1:0]                 row_q, row_d;
  logic [tccw_pkg::COLOUR_W-1:0]   fg_q, bg_q;
  logic                            scroll_q, scroll_d;
  logic                            rd_ok_q, rd_ok_d;
  logic                            out_valid_q, out_valid_d;
  logic [OutColW-1:0]              out_col_q, out_col_d;
  logic [OutRowW-1:0]              out_row_q, out_row_d;
  logic [OffW-1:0]                 out_off_q, out_off_d;
  logic [CellW-1:0]                out_cell_q, out_cell_d;
  logic                            out_scr_q, out_scr_d;

  logic                            ram_we, ram_re;
  logic [AddrW-1:0]                ram_waddr, ram_raddr;
  logic [CellW-1:0]                ram_wdata, ram_rdata;

  logic [NextW-1:0]                tab_stop [2**ColW];
  logic [NextW-1:0]                ncol;
  logic                            step_row;
  logic                            post;
  logic [CellW-1:0]                post_cell;
  logic                            post_scr;
  logic [CellW-1:0]                blank;
  logic [AddrW:0]                  scroll_src;

  // Next tab stop for each column, worked out at elaboration.
  for (genvar g = 0; g < 2**ColW; g++) begin : g_tab
    localparam int Stop = (g / TAB_WIDTH + 1) * TAB_WIDTH;
    assign tab_stop[g] = NextW'(Stop);
  end

  tccw_ram #(
    .WIDTH (CellW),
    .DEPTH (Cells)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign blank       = {bg_q, fg_q, tccw_pkg::CH_SPACE};
  assign scroll_src  = {1'b0, ptr_q} + (AddrW + 1)'(COLS);
  assign init_busy_o = (state_q == ST_INIT);
  assign cmd_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);

  // Command sequencing and screen memory control.
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    col_d     = col_q;
    row_d     = row_q;
    scroll_d  = scroll_q;
    rd_ok_d   = rd_ok_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata = '0;
    post      = 1'b0;
    post_cell = '0;
    post_scr  = 1'b0;
    ncol      = NextW'(col_q);
    step_row  = 1'b0;

    unique case (state_q)
      // Clearing pass after reset, in the reset colours.
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = tccw_pkg::RESET_BLANK;
        if (ptr_q == LastCell) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end

      ST_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          unique case (cmd_i.op)
            tccw_pkg::OP_BS: begin
              ncol = (col_q == '0) ? '0 : NextW'(col_q) - NextW'(1);
            end
            tccw_pkg::OP_TAB: begin
              ncol = tab_stop[col_q];
            end
            tccw_pkg::OP_CR: begin
              ncol = '0;
            end
            tccw_pkg::OP_LF: begin
              ncol     = '0;
              step_row = 1'b1;
            end
            tccw_pkg::OP_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = AddrW'(int'(row_q) * COLS + int'(col_q));
              ram_wdata = {bg_q, fg_q, cmd_i.char_code};
              ncol      = NextW'(col_q) + NextW'(1);
            end
            tccw_pkg::OP_CLEAR: begin
              ncol = '0;
            end
            tccw_pkg::OP_SETCOL: begin
              ncol = NextW'(cmd_i.col);
            end
            tccw_pkg::OP_SETROW: begin
              row_d = RowW'(cmd_i.row);
            end
            tccw_pkg::OP_READ: begin
              rd_ok_d   = (32'(cmd_i.index) < 32'(Cells));
              ram_re    = rd_ok_d;
              ram_raddr = AddrW'(cmd_i.index);
            end
            default: begin
              ncol = NextW'(col_q);
            end
          endcase

          // Column wrap onto a new line.
          if (ncol >= NextW'(COLS)) begin
            ncol     = '0;
            step_row = 1'b1;
          end
          col_d = ColW'(ncol);

          priority if (cmd_i.op == tccw_pkg::OP_CLEAR) begin
            row_d    = '0;
            ptr_d    = '0;
            scroll_d = 1'b0;
            state_d  = ST_FILL;
          end else if (cmd_i.op == tccw_pkg::OP_READ) begin
            state_d = ST_READ;
          end else if (step_row && (row_q == RowW'(ROWS - 1))) begin
            ptr_d    = '0;
            scroll_d = 1'b1;
            state_d  = ST_SCROLL;
          end else begin
            if (step_row) begin
              row_d = row_q + RowW'(1);
            end
            post = 1'b1;
          end
        end
      end

      // Move every line up: read one line below, write it back in the next cycle.
      ST_SCROLL: begin
        if (ptr_q != MoveEnd) begin
          ram_re    = 1'b1;
          ram_raddr = AddrW'(scroll_src);
        end
        if (ptr_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q - AddrW'(1);
          ram_wdata = ram_rdata;
        end
        if (ptr_q == MoveEnd) begin
          state_d = ST_FILL;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end

      // Blank from the pointer to the end of the screen.
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = blank;
        if (ptr_q == LastCell) begin
          ptr_d    = '0;
          post     = 1'b1;
          post_scr = scroll_q;
          state_d  = ST_IDLE;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end

      ST_READ: begin
        post      = 1'b1;
        post_cell = rd_ok_q ? ram_rdata : '0;
        state_d   = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result word: held until taken, loaded when a command completes.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_off_d   = out_off_q;
    out_cell_d  = out_cell_q;
    out_scr_d   = out_scr_q;
    if (post) begin
      out_valid_d = 1'b1;
      out_col_d   = OutColW'(col_d);
      out_row_d   = OutRowW'(row_d);
      out_off_d   = OffW'(int'(row_d) * COLS + int'(col_d));
      out_cell_d  = post_cell;
      out_scr_d   = post_scr;
    end
  end

  // State, cursor, colours and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ptr_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      fg_q        <= tccw_pkg::FG_RESET;
      bg_q        <= tccw_pkg::BG_RESET;
      scroll_q    <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      col_q       <= col_d;
      row_q       <= row_d;
      scroll_q    <= scroll_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == tccw_pkg::CFG_FG) begin
          fg_q <= cfg_data_i;
        end
        if (cfg_index_i == tccw_pkg::CFG_BG) begin
          bg_q <= cfg_data_i;
        end
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_off_q  <= out_off_d;
    out_cell_q <= out_cell_d;
    out_scr_q  <= out_scr_d;
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_col_o    = out_col_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_offset_o = out_off_q;
  assign cell_word_o     = out_cell_q;
  assign scrolled_o      = out_scr_q;

endmodule

[design/text_console_character_writer.sv]
// ----------------------------------------------------------------------------
// Text console character writer
// Text screen of COLS x ROWS cells with a cursor: puts characters, clears,
// positions the cursor and reads cells, one result word per input word.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Word
//  in       input      in_valid/in_ready    action, char_code, new_col,
//                                           new_row, cell_index
//  out      output     out_valid/out_ready  cursor_col, cursor_row,
//                                           cursor_offset, cell_word, scrolled
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A word passes the front queue to the back end. Cursor moves and printable
// characters are carried out from the idle state, a cell read goes through
// the registered read port, and a clear or a scroll sweeps the screen cell by
// cell through the single write port of the screen memory.
// After reset a clearing pass writes a blank to each of the COLS*ROWS cells;
// no input word is accepted during it, configuration writes are.
// A result waits in the output register while the next word is queued.
//
module text_console_character_writer #(
  parameter int COLS      = tccw_pkg::COLS_DEF,
  parameter int ROWS      = tccw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tccw_pkg::TAB_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tccw_pkg::ACTION_W-1:0]   action_i,
  input  logic [tccw_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tccw_pkg::POS_IN_W-1:0]   new_col_i,
  input  logic [tccw_pkg::POS_IN_W-1:0]   new_row_i,
  input  logic [tccw_pkg::INDEX_W-1:0]    cell_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tccw_pkg::OUT_COL_W-1:0]  cursor_col_o,
  output logic [tccw_pkg::OUT_ROW_W-1:0]  cursor_row_o,
  output logic [tccw_pkg::OFFSET_W-1:0]   cursor_offset_o,
  output logic [tccw_pkg::CELL_W-1:0]     cell_word_o,
  output logic                            scrolled_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tccw_pkg::COLOUR_W-1:0]   cfg_data_i
);

  tccw_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;
  logic           init_busy;

  // Colour registers are always ready to take a write.
  assign cfg_ready_o = 1'b1;

  tccw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_busy_i  (init_busy),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .char_code_i  (char_code_i),
    .new_col_i    (new_col_i),
    .new_row_i    (new_row_i),
    .cell_index_i (cell_index_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  tccw_back #(
    .COLS      (COLS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .init_busy_o     (init_busy),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .cmd_i           (cmd),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cursor_col_o    (cursor_col_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_offset_o (cursor_offset_o),
    .cell_word_o     (cell_word_o),
    .scrolled_o      (scrolled_o)
  );

endmodule

[verif/text_console_character_writer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer: self-checking testbench
// Drives words into the console through the input channel, with bursts and
// gaps, while the result channel stalls on a pattern of its own. A screen
// model held here predicts each cursor report and cell read. A short table
// of directed words comes first, then phases of random text, cursor moves,
// reads and clears under several colour settings.
// ----------------------------------------------------------------------------
module text_console_character_writer_tb;
  import tccw_pkg::*;

  localparam int COLS      = COLS_DEF;
  localparam int ROWS      = ROWS_DEF;
  localparam int TAB_WIDTH = TAB_WIDTH_DEF;
  localparam int CELLS     = COLS * ROWS;

  localparam int          CLK_PERIOD   = 10;
  localparam int          WORDS_PHASE  = 60;
  localparam int          PHASES       = 5;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  // Codes and limits used by the stimulus.
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI  = 3'd7;
  localparam logic [CHAR_W-1:0]   CH_NUL        = 8'h00;
  localparam logic [CHAR_W-1:0]   CH_CTRL_LAST  = 8'h1F;
  localparam logic [CHAR_W-1:0]   CH_DEL        = 8'h7F;
  localparam logic [CHAR_W-1:0]   CH_HIGH_FIRST = 8'h80;
  localparam logic [CHAR_W-1:0]   CH_HIGH_LAST  = 8'hFF;
  localparam logic [POS_IN_W-1:0] POS_MAX       = 8'hFF;
  localparam logic [INDEX_W-1:0]  INDEX_MAX     = 11'h7FF;
  localparam logic [COLOUR_W-1:0] COLOUR_MIN    = 4'h0;
  localparam logic [COLOUR_W-1:0] COLOUR_MAX    = 4'hF;

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_SPARSE} ready_mode_e;

  // One cursor report as it leaves the block.
  typedef struct packed {
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    logic [OFFSET_W-1:0]  offset;
    logic [CELL_W-1:0]    cell_word;
    logic                 scrolled;
  } console_report_t;

  // One input word, with a report typed in by hand where it is known.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [POS_IN_W-1:0] new_col;
    logic [POS_IN_W-1:0] new_row;
    logic [INDEX_W-1:0]  cell_index;
    logic                known;
    console_report_t     report;
  } console_word_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [ACTION_W-1:0]  action_i     = '0;
  logic [CHAR_W-1:0]    char_code_i  = '0;
  logic [POS_IN_W-1:0]  new_col_i    = '0;
  logic [POS_IN_W-1:0]  new_row_i    = '0;
  logic [INDEX_W-1:0]   cell_index_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [OUT_COL_W-1:0] cursor_col_o;
  logic [OUT_ROW_W-1:0] cursor_row_o;
  logic [OFFSET_W-1:0]  cursor_offset_o;
  logic [CELL_W-1:0]    cell_word_o;
  logic                 scrolled_o;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [COLOUR_W-1:0]  cfg_data_i   = '0;

  // Screen model and its colour registers.
  logic [CELL_W-1:0]   screen_model [0:CELLS-1];
  int                  model_col;
  int                  model_row;
  logic [COLOUR_W-1:0] model_fg = FG_RESET;
  logic [COLOUR_W-1:0] model_bg = BG_RESET;

  console_report_t reports_due [$];
  console_word_t   directed_words [$];
  int              mismatches  = 0;
  int              burst_left  = 0;
  int unsigned     cycle_count = 0;
  ready_mode_e     ready_mode  = READY_ALWAYS;
  int              ready_left  = 0;

  text_console_character_writer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .char_code_i     (char_code_i),
    .new_col_i       (new_col_i),
    .new_row_i       (new_row_i),
    .cell_index_i    (cell_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cursor_col_o    (cursor_col_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_offset_o (cursor_offset_o),
    .cell_word_o     (cell_word_o),
    .scrolled_o      (scrolled_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Blank a range of model cells in the current colours.
  function automatic void fill_blanks(input int from, input int upto);
    for (int i = from; i < upto; i++) begin
      screen_model[i] = {model_bg, model_fg, CH_SPACE};
    end
  endfunction

  // Apply one word to the screen model and return the report it causes.
  function automatic console_report_t apply_console_word(input console_word_t w);
    console_report_t rep;
    int              col;
    int              row;
    col = model_col;
    row = model_row;
    rep = '0;
    case (w.action)
      ACT_PUT: begin
        if (w.char_code == CH_BS) begin
          if (col != 0) col--;
        end else if (w.char_code == CH_TAB) begin
          col = (col / TAB_WIDTH + 1) * TAB_WIDTH;
        end else if (w.char_code == CH_CR) begin
          col = 0;
        end else if (w.char_code == CH_LF) begin
          col = 0;
          row++;
        end else if (w.char_code >= CH_SPACE && w.char_code <= CH_DEL) begin
          screen_model[row * COLS + col] = {model_bg, model_fg, w.char_code};
          col++;
        end
        if (col >= COLS) begin
          col = 0;
          row++;
        end
        // Off the bottom: move every line up one and blank the last.
        if (row >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
            screen_model[i] = screen_model[i + COLS];
          end
          fill_blanks((ROWS - 1) * COLS, CELLS);
          row          = ROWS - 1;
          rep.scrolled = 1'b1;
        end
      end
      ACT_CLEAR: begin
        fill_blanks(0, CELLS);
        col = 0;
        row = 0;
      end
      ACT_SETCOL: col = (w.new_col > COLS - 1) ? COLS - 1 : int'(w.new_col);
      ACT_SETROW: row = (w.new_row > ROWS - 1) ? ROWS - 1 : int'(w.new_row);
      ACT_READ: begin
        if (w.cell_index < CELLS) rep.cell_word = screen_model[w.cell_index];
      end
      default: ;
    endcase
    model_col  = col;
    model_row  = row;
    rep.col    = col[OUT_COL_W-1:0];
    rep.row    = row[OUT_ROW_W-1:0];
    rep.offset = OFFSET_W'(row * COLS + col);
    return rep;
  endfunction

  // Table rows: one checked against the model, one with its report typed in.
  task automatic row_checked(input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] code,
                             input logic [POS_IN_W-1:0] ncol, input logic [POS_IN_W-1:0] nrow,
                             input logic [INDEX_W-1:0] idx);
    console_word_t w;
    w = '{act, code, ncol, nrow, idx, 1'b0, '0};
    directed_words.push_back(w);
  endtask

  task automatic row_known(input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] code,
                           input logic [POS_IN_W-1:0] ncol, input logic [POS_IN_W-1:0] nrow,
                           input logic [INDEX_W-1:0] idx, input logic [OUT_COL_W-1:0] col,
                           input logic [OUT_ROW_W-1:0] row, input logic [OFFSET_W-1:0] offset,
                           input logic [CELL_W-1:0] word_val, input logic scr);
    console_word_t w;
    w = '{act, code, ncol, nrow, idx, 1'b1,
          console_report_t'({col, row, offset, word_val, scr})};
    directed_words.push_back(w);
  endtask

  // Write both colour registers back to back.
  task automatic write_colours(input logic [COLOUR_W-1:0] fg, input logic [COLOUR_W-1:0] bg);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_FG;
    cfg_data_i  <= fg;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    model_fg = fg;
    cfg_index_i <= CFG_BG;
    cfg_data_i  <= bg;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    model_bg = bg;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one word; the sender pauses between bursts of random length.
  task automatic send_word(input console_word_t w);
    console_report_t rep;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
    end
    in_valid_i   <= 1'b1;
    action_i     <= w.action;
    char_code_i  <= w.char_code;
    new_col_i    <= w.new_col;
    new_row_i    <= w.new_row;
    cell_index_i <= w.cell_index;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rep = apply_console_word(w);
    reports_due.push_back(w.known ? w.report : rep);
    burst_left--;
  endtask

  // Close a phase: drop valid and let every report come back.
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (reports_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] due_val,
                             input logic [31:0] got_val);
    if (due_val !== got_val) begin
      $error("%s: expected %0h, got %0h", name, due_val, got_val);
      mismatches++;
    end
  endtask

  // Receiver: picks a new stall pattern whenever the current one runs out.
  always @(posedge clk_i) begin
    console_report_t due;
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 2));
      ready_left = $urandom_range(8, 120);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready_i <= 1'b1;
      READY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
      default:      out_ready_i <= (ready_left % 4 == 0);
    endcase
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reports_due.size() == 0) begin
        $error("result word with none outstanding: col %0d row %0d",
               cursor_col_o, cursor_row_o);
        mismatches++;
      end else begin
        due = reports_due.pop_front();
        check_field("cursor_col", 32'(due.col), 32'(cursor_col_o));
        check_field("cursor_row", 32'(due.row), 32'(cursor_row_o));
        check_field("cursor_offset", 32'(due.offset), 32'(cursor_offset_o));
        check_field("cell_word", 32'(due.cell_word), 32'(cell_word_o));
        check_field("scrolled", 32'(due.scrolled), 32'(scrolled_o));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** text_console_character_writer: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    console_word_t w;
    int            sel;
    int            sub;

    fill_blanks(0, CELLS);
    model_col = 0;
    model_row = 0;

    // Directed table, starting from the screen as reset leaves it.
    row_known(ACT_READ, CH_NUL, '0, '0, '0, '0, '0, '0, RESET_BLANK, 1'b0);
    row_known(ACT_READ, CH_NUL, '0, '0, INDEX_W'(CELLS - 1), '0, '0, '0, RESET_BLANK, 1'b0);
    row_known(ACT_READ, CH_NUL, '0, '0, INDEX_MAX, '0, '0, '0, '0, 1'b0);
    row_known(ACT_READ, CH_NUL, '0, '0, INDEX_W'(CELLS), '0, '0, '0, '0, 1'b0);
    row_known(ACT_PUT, CH_BS, '0, '0, '0, '0, '0, '0, '0, 1'b0);
    row_checked(ACT_PUT, CH_SPACE, '0, '0, '0);
    row_checked(ACT_PUT, CH_DEL, '0, '0, '0);
    row_checked(ACT_PUT, CH_HIGH_FIRST, '0, '0, '0);
    row_checked(ACT_PUT, CH_HIGH_LAST, '0, '0, '0);
    row_checked(ACT_PUT, CH_NUL, '0, '0, '0);
    row_checked(ACT_PUT, CH_CTRL_LAST, '0, '0, '0);
    row_checked(ACT_PUT, CH_TAB, '0, '0, '0);
    row_checked(ACT_PUT, CH_BS, '0, '0, '0);
    row_checked(ACT_PUT, CH_CR, '0, '0, '0);
    row_checked(ACT_PUT, CH_LF, '0, '0, '0);
    row_checked(ACT_SETCOL, CH_NUL, POS_MAX, '0, '0);
    row_checked(ACT_PUT, "Z", '0, '0, '0);
    row_checked(ACT_SETCOL, CH_NUL, POS_IN_W'(COLS - 1), '0, '0);
    row_checked(ACT_PUT, CH_TAB, '0, '0, '0);
    row_checked(ACT_SETROW, CH_NUL, '0, POS_MAX, '0);
    row_checked(ACT_PUT, CH_LF, '0, '0, '0);
    row_checked(ACT_SETCOL, CH_NUL, POS_IN_W'(COLS - 1), '0, '0);
    row_checked(ACT_PUT, "x", '0, '0, '0);
    row_checked(ACT_READ, CH_NUL, '0, '0, INDEX_W'((ROWS - 1) * COLS - 1));
    row_checked(ACT_SPARE_LO, CH_NUL, '0, '0, '0);
    row_checked(ACT_SPARE_HI, CH_NUL, '0, '0, '0);
    row_checked(ACT_CLEAR, CH_NUL, '0, '0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_colours(FG_RESET, BG_RESET);

    foreach (directed_words[i]) send_word(directed_words[i]);
    drain_reports();

    // Random phases, each under its own colours.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       write_colours(COLOUR_MIN, COLOUR_MIN);
        1:       write_colours(COLOUR_MAX, COLOUR_MAX);
        2:       write_colours(COLOUR_MIN, COLOUR_MAX);
        default: write_colours(COLOUR_W'($urandom_range(0, 15)),
                               COLOUR_W'($urandom_range(0, 15)));
      endcase
      for (int n = 0; n < WORDS_PHASE; n++) begin
        // Unused fields carry noise.
        w.action     = ACT_PUT;
        w.char_code  = CHAR_W'($urandom);
        w.new_col    = POS_IN_W'($urandom);
        w.new_row    = POS_IN_W'($urandom);
        w.cell_index = INDEX_W'($urandom);
        w.known      = 1'b0;
        w.report     = '0;
        sel = $urandom_range(0, 99);
        sub = $urandom_range(0, 99);
        if (sel < 55) begin
          // Mostly text, with line control mixed in.
          if (sub < 70) begin
            w.char_code = CHAR_W'($urandom_range(CH_SPACE, CH_DEL));
          end else if (sub < 78) begin
            w.char_code = CH_LF;
          end else if (sub < 82) begin
            w.char_code = CH_CR;
          end else if (sub < 87) begin
            w.char_code = CH_TAB;
          end else if (sub < 92) begin
            w.char_code = CH_BS;
          end else if (sub < 96) begin
            w.char_code = CHAR_W'($urandom_range(CH_HIGH_FIRST, CH_HIGH_LAST));
          end else begin
            w.char_code = CHAR_W'($urandom_range(CH_NUL, CH_CTRL_LAST));
          end
        end else if (sel < 65) begin
          w.action = ACT_SETCOL;
          if (sub < 50) w.new_col = POS_IN_W'($urandom_range(0, COLS - 1));
        end else if (sel < 72) begin
          w.action = ACT_SETROW;
          if (sub < 50) w.new_row = POS_IN_W'($urandom_range(0, ROWS - 1));
        end else if (sel < 93) begin
          w.action = ACT_READ;
          if (sub < 85) w.cell_index = INDEX_W'($urandom_range(0, CELLS - 1));
        end else if (sel < 95) begin
          w.action = ACT_CLEAR;
        end else begin
          w.action = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end
        send_word(w);
      end
      drain_reports();
    end

    // Room for any stray result after the last one.
    repeat (CELLS + 100) @(posedge clk_i);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("** text_console_character_writer: PASSED **");
    end else begin
      $display("** text_console_character_writer: FAILED **");
    end
    $finish;
  end

endmodule
